// ----- rtl/qme_pkg.sv -----
`default_nettype none

package qme_pkg;

	// data path and field widths
	localparam int DATA_W      = 16;
	localparam int MODE_W      = 5;
	localparam int REG_IDX_W   = 5;
	localparam int TGT_W       = 10;
	localparam int NUM_REGS    = 26;
	localparam int QUEUE_DEPTH = 256;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_W + 1);
	localparam int CHAR_W      = 8;

	// instruction codes
	localparam logic [MODE_W-1:0] OP_PUSH    = 5'd0;
	localparam logic [MODE_W-1:0] OP_ADD     = 5'd1;
	localparam logic [MODE_W-1:0] OP_SUB     = 5'd2;
	localparam logic [MODE_W-1:0] OP_MUL     = 5'd3;
	localparam logic [MODE_W-1:0] OP_DIV     = 5'd4;
	localparam logic [MODE_W-1:0] OP_MOD     = 5'd5;
	localparam logic [MODE_W-1:0] OP_POPREG  = 5'd6;
	localparam logic [MODE_W-1:0] OP_PUSHREG = 5'd7;
	localparam logic [MODE_W-1:0] OP_PRINTQ  = 5'd8;
	localparam logic [MODE_W-1:0] OP_PRINTR  = 5'd9;
	localparam logic [MODE_W-1:0] OP_PRINTCQ = 5'd10;
	localparam logic [MODE_W-1:0] OP_PRINTCR = 5'd11;
	localparam logic [MODE_W-1:0] OP_JMP     = 5'd12;
	localparam logic [MODE_W-1:0] OP_JZ      = 5'd13;
	localparam logic [MODE_W-1:0] OP_JEQ     = 5'd14;
	localparam logic [MODE_W-1:0] OP_JGT     = 5'd15;
	localparam logic [MODE_W-1:0] OP_QUIT    = 5'd16;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POPX,
		S_POPY,
		S_EXEC,
		S_DIV,
		S_POP1,
		S_REGB
	} state_t;

	// queue control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/qme_div.sv -----
`default_nettype none

module qme_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [qme_pkg::DATA_W-1:0]   dividend,
	input  wire  [qme_pkg::DATA_W-1:0]   divisor,
	output logic                         done,
	output logic [qme_pkg::DATA_W-1:0]   quot,
	output logic [qme_pkg::DATA_W-1:0]   rem
);
	import qme_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DATA_W-1:0]    q_q;
	logic [DATA_W-1:0]    r_q;
	logic [DATA_W-1:0]    d_q;
	logic [DATA_W:0]      trial;
	logic                 fits;
	logic [DATA_W:0]      diff;

	// one restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {r_q, q_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= DIV_CNT_W'(DATA_W);
				q_q   <= dividend;
				r_q   <= '0;
				d_q   <= divisor;
			end else if (cnt_q != '0) begin
				r_q   <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				q_q   <= {q_q[DATA_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

// ----- rtl/qme_queue.sv -----
`default_nettype none

module qme_queue (
	input  wire                          clk,
	input  wire                          arst_n,
	input  qme_pkg::q_ctl_t              ctl,
	input  wire  [qme_pkg::DATA_W-1:0]   wdata,
	output logic [qme_pkg::DATA_W-1:0]   rdata,
	output logic [qme_pkg::CNT_W-1:0]    count
);
	import qme_pkg::*;

	logic [DATA_W-1:0] mem [0:QUEUE_DEPTH-1];
	logic [DATA_W-1:0] rdata_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [PTR_W-1:0]  head_nxt;
	logic [PTR_W-1:0]  tail_nxt;

	// circular pointers
	assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// storage, write at tail and registered read at head
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[head_q];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= tail_nxt;
			end
			if (ctl.pop) begin
				head_q <= head_nxt;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

endmodule

`default_nettype wire

// ----- rtl/queue_machine_execute_top.sv -----
// channel  direction  beat contents
// in       sink       mode, reg_first, reg_second, immediate, jump_target
// out      source     print_valid, print_is_char, print_value, branch_taken,
//                     branch_to, halted, error_code
//
// one instruction at a time; in_ready returns in the cycle after its result beat leaves
// result beat loaded in DECODE for push, register prints, jz, jmp, quit, nop, errors;
// POP1 for pops; REGB for jeq, jgt; EXEC after POPX, POPY (queue reads) for add, sub,
// mul and zero divisor; DIV for div and mod (shared one-bit-per-cycle divider, 16 steps)
// reset clears registers, queue pointers and halt; queue contents are not cleared
// a stalled result holds in the output register and blocks the next accept
`default_nettype none

module queue_machine_execute_top (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [qme_pkg::MODE_W-1:0]      mode,
	input  wire  [qme_pkg::REG_IDX_W-1:0]   reg_first,
	input  wire  [qme_pkg::REG_IDX_W-1:0]   reg_second,
	input  wire  [qme_pkg::DATA_W-1:0]      immediate,
	input  wire  [qme_pkg::TGT_W-1:0]       jump_target,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic                            print_valid,
	output logic                            print_is_char,
	output logic [qme_pkg::DATA_W-1:0]      print_value,
	output logic                            branch_taken,
	output logic [qme_pkg::TGT_W-1:0]       branch_to,
	output logic                            halted,
	output logic [1:0]                      error_code
);
	import qme_pkg::*;

	state_t               state_q;
	state_t               state_d;

	// latched instruction
	logic [MODE_W-1:0]    mode_q;
	logic [REG_IDX_W-1:0] ra_q;
	logic [REG_IDX_W-1:0] rb_q;
	logic [DATA_W-1:0]    imm_q;
	logic [TGT_W-1:0]     tgt_q;

	logic [DATA_W-1:0]    opa_q;
	logic [DATA_W-1:0]    opb_q;
	logic                 halt_q;
	logic [DATA_W-1:0]    rf_q [0:NUM_REGS-1];

	// result register
	logic                 out_valid_q;
	logic                 pv_q;
	logic                 pc_q;
	logic [DATA_W-1:0]    pval_q;
	logic                 bt_q;
	logic [TGT_W-1:0]     bto_q;
	logic                 hlt_q;
	err_t                 err_q;

	// sequencer controls
	q_ctl_t               q_ctl;
	logic [DATA_W-1:0]    q_wdata;
	logic [DATA_W-1:0]    q_rdata;
	logic [CNT_W-1:0]     q_count;
	logic                 rf_we;
	logic [DATA_W-1:0]    rf_wdata;
	logic                 div_start;
	logic                 div_done;
	logic [DATA_W-1:0]    div_quot;
	logic [DATA_W-1:0]    div_rem;
	logic                 ld_res;
	logic                 ld_opa;
	logic                 ld_opb;
	logic [DATA_W-1:0]    opa_src;
	logic                 set_halt;
	logic                 res_pv;
	logic                 res_pc;
	logic [DATA_W-1:0]    res_pval;
	logic                 res_bt;
	err_t                 res_err;

	logic                 in_fire;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_lt2;
	logic                 is_bin;
	logic                 is_pop1;
	logic                 is_cmp2;
	logic [REG_IDX_W-1:0] rd_idx;
	logic [DATA_W-1:0]    rd_data;
	logic [2*DATA_W-1:0]  mul_full;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign in_fire  = in_valid && in_ready;

	// queue and divider
	qme_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wdata  (q_wdata),
		.rdata  (q_rdata),
		.count  (q_count)
	);

	qme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (opa_q),
		.divisor  (opb_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// queue level checks and opcode classes
	assign q_full  = q_count == CNT_W'(QUEUE_DEPTH);
	assign q_empty = q_count == '0;
	assign q_lt2   = q_count < CNT_W'(2);
	assign is_bin  = (mode_q == OP_ADD) || (mode_q == OP_SUB) || (mode_q == OP_MUL) ||
	                 (mode_q == OP_DIV) || (mode_q == OP_MOD);
	assign is_pop1 = (mode_q == OP_POPREG) || (mode_q == OP_PRINTQ) ||
	                 (mode_q == OP_PRINTCQ);
	assign is_cmp2 = (mode_q == OP_JEQ) || (mode_q == OP_JGT);

	// single register read port, second operand only in its own step
	assign rd_idx  = (state_q == S_REGB) ? rb_q : ra_q;
	assign rd_data = (rd_idx < REG_IDX_W'(NUM_REGS)) ? rf_q[rd_idx] : '0;

	assign mul_full = {{DATA_W{1'b0}}, opa_q} * {{DATA_W{1'b0}}, opb_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (halt_q) begin
					state_d = S_IDLE;
				end else if (is_bin && !q_lt2) begin
					state_d = S_POPX;
				end else if (is_pop1 && !q_empty) begin
					state_d = S_POP1;
				end else if (is_cmp2) begin
					state_d = S_REGB;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_POPX:  state_d = S_POPY;
			S_POPY:  state_d = S_EXEC;
			S_EXEC: begin
				if (((mode_q == OP_DIV) || (mode_q == OP_MOD)) && (opb_q != '0)) begin
					state_d = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_IDLE;
				end
			end
			S_POP1:  state_d = S_IDLE;
			S_REGB:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_ctl     = '0;
		q_wdata   = '0;
		rf_we     = 1'b0;
		rf_wdata  = q_rdata;
		div_start = 1'b0;
		ld_res    = 1'b0;
		ld_opa    = 1'b0;
		ld_opb    = 1'b0;
		opa_src   = q_rdata;
		set_halt  = 1'b0;
		res_pv    = 1'b0;
		res_pc    = 1'b0;
		res_pval  = '0;
		res_bt    = 1'b0;
		res_err   = ERR_NONE;
		case (state_q)
			S_DECODE: begin
				if (halt_q) begin
					ld_res = 1'b1;
				end else begin
					case (mode_q)
						OP_PUSH, OP_PUSHREG: begin
							ld_res = 1'b1;
							if (q_full) begin
								res_err = ERR_OVER;
							end else begin
								q_ctl.push = 1'b1;
								q_wdata    = (mode_q == OP_PUSH) ? imm_q : rd_data;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
							if (q_lt2) begin
								ld_res  = 1'b1;
								res_err = ERR_UNDER;
							end else begin
								q_ctl.pop = 1'b1;
							end
						end
						OP_POPREG, OP_PRINTQ, OP_PRINTCQ: begin
							if (q_empty) begin
								ld_res  = 1'b1;
								res_err = ERR_UNDER;
							end else begin
								q_ctl.pop = 1'b1;
							end
						end
						OP_PRINTR: begin
							ld_res   = 1'b1;
							res_pv   = 1'b1;
							res_pval = rd_data;
						end
						OP_PRINTCR: begin
							ld_res   = 1'b1;
							res_pv   = 1'b1;
							res_pc   = 1'b1;
							res_pval = {{(DATA_W-CHAR_W){1'b0}}, rd_data[CHAR_W-1:0]};
						end
						OP_JMP: begin
							ld_res = 1'b1;
							res_bt = 1'b1;
						end
						OP_JZ: begin
							ld_res = 1'b1;
							res_bt = rd_data == '0;
						end
						OP_JEQ, OP_JGT: begin
							ld_opa  = 1'b1;
							opa_src = rd_data;
						end
						OP_QUIT: begin
							ld_res   = 1'b1;
							set_halt = 1'b1;
						end
						default: begin
							ld_res = 1'b1;
						end
					endcase
				end
			end
			S_POPX: begin
				ld_opa    = 1'b1;
				q_ctl.pop = 1'b1;
			end
			S_POPY: begin
				ld_opb = 1'b1;
			end
			S_EXEC: begin
				case (mode_q)
					OP_ADD: begin
						q_ctl.push = 1'b1;
						q_wdata    = opa_q + opb_q;
						ld_res     = 1'b1;
					end
					OP_SUB: begin
						q_ctl.push = 1'b1;
						q_wdata    = opa_q - opb_q;
						ld_res     = 1'b1;
					end
					OP_MUL: begin
						q_ctl.push = 1'b1;
						q_wdata    = mul_full[DATA_W-1:0];
						ld_res     = 1'b1;
					end
					default: begin
						// zero divisor gives zero without running the divider
						if (opb_q == '0) begin
							q_ctl.push = 1'b1;
							ld_res     = 1'b1;
						end else begin
							div_start = 1'b1;
						end
					end
				endcase
			end
			S_DIV: begin
				if (div_done) begin
					q_ctl.push = 1'b1;
					q_wdata    = (mode_q == OP_DIV) ? div_quot : div_rem;
					ld_res     = 1'b1;
				end
			end
			S_POP1: begin
				ld_res = 1'b1;
				case (mode_q)
					OP_POPREG: begin
						rf_we = ra_q < REG_IDX_W'(NUM_REGS);
					end
					OP_PRINTQ: begin
						res_pv   = 1'b1;
						res_pval = q_rdata;
					end
					default: begin
						res_pv   = 1'b1;
						res_pc   = 1'b1;
						res_pval = {{(DATA_W-CHAR_W){1'b0}}, q_rdata[CHAR_W-1:0]};
					end
				endcase
			end
			S_REGB: begin
				ld_res = 1'b1;
				res_bt = (mode_q == OP_JEQ) ? (opa_q == rd_data) : (opa_q > rd_data);
			end
			default: begin
			end
		endcase
	end

	// state, halt flag and register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			halt_q  <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (set_halt) begin
				halt_q <= 1'b1;
			end
			if (rf_we) begin
				rf_q[ra_q] <= rf_wdata;
			end
		end
	end

	// instruction and operand holding
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_q <= mode;
			ra_q   <= reg_first;
			rb_q   <= reg_second;
			imm_q  <= immediate;
			tgt_q  <= jump_target;
		end
		if (ld_opa) begin
			opa_q <= opa_src;
		end
		if (ld_opb) begin
			opb_q <= q_rdata;
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_res) begin
			pv_q   <= res_pv;
			pc_q   <= res_pc;
			pval_q <= res_pval;
			bt_q   <= res_bt;
			bto_q  <= res_bt ? tgt_q : '0;
			hlt_q  <= halt_q || set_halt;
			err_q  <= res_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign print_valid   = pv_q;
	assign print_is_char = pc_q;
	assign print_value   = pval_q;
	assign branch_taken  = bt_q;
	assign branch_to     = bto_q;
	assign halted        = hlt_q;
	assign error_code    = err_q;

`ifndef ASSERT_OFF
	a_no_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_ctl.push && q_ctl.pop))
		else $error("queue push and pop in the same cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill level beyond depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (opb_q != '0))
		else $error("divider started with zero divisor");

	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && div_done |=> out_valid_q && (state_q == S_IDLE))
		else $error("division result not delivered");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qme_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int RESET_CYCLES = 3;
	localparam int IDLE_PCT    = 23;
	localparam int HOLD_CYCLES = 400;
	localparam int STEADY_LEN  = 180;
	localparam int END_WAIT    = 40;
	localparam int CYCLE_LIMIT = 500_000;
	localparam int MAX_REPORTS = 10;
	localparam int RANDOM_ITEMS = 850;
	localparam int OVERFLOW_TRIES = 3;

	// opcodes with no name in the package
	localparam logic [MODE_W-1:0] OP_NOP          = 5'd17;
	localparam logic [MODE_W-1:0] OP_UNUSED_FIRST = 5'd18;
	localparam logic [MODE_W-1:0] OP_UNUSED_LAST  = 5'd31;

	// register indexes used by the directed tests
	localparam logic [REG_IDX_W-1:0] REG_A   = 5'd0;
	localparam logic [REG_IDX_W-1:0] REG_B   = 5'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y   = REG_IDX_W'(NUM_REGS - 2);
	localparam logic [REG_IDX_W-1:0] REG_Z   = REG_IDX_W'(NUM_REGS - 1);
	localparam logic [REG_IDX_W-1:0] REG_MAX = '1;
	localparam logic [REG_IDX_W-1:0] REG_OOR = REG_MAX - 1'b1;

	localparam logic [DATA_W-1:0] DATA_MAX = '1;
	localparam logic [TGT_W-1:0]  TGT_MAX  = '1;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [REG_IDX_W-1:0] reg_first;
		logic [REG_IDX_W-1:0] reg_second;
		logic [DATA_W-1:0]    immediate;
		logic [TGT_W-1:0]     jump_target;
	} instr_t;

	typedef struct packed {
		logic              print_valid;
		logic              print_is_char;
		logic [DATA_W-1:0] print_value;
		logic              branch_taken;
		logic [TGT_W-1:0]  branch_to;
		logic              halted;
		err_t              error_code;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [MODE_W-1:0]    mode = '0;
	logic [REG_IDX_W-1:0] reg_first = '0;
	logic [REG_IDX_W-1:0] reg_second = '0;
	logic [DATA_W-1:0]    immediate = '0;
	logic [TGT_W-1:0]     jump_target = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic print_valid;
	logic print_is_char;
	logic [DATA_W-1:0] print_value;
	logic branch_taken;
	logic [TGT_W-1:0] branch_to;
	logic halted;
	logic [1:0] error_code;

	// machine state as predicted
	logic [DATA_W-1:0] vm_regs [NUM_REGS];
	logic [DATA_W-1:0] vm_queue [$];
	logic              vm_halted;

	outcome_t expected_outcomes [$];
	int mismatch_count = 0;
	int result_beats = 0;
	int cycle_count = 0;

	// idling control
	logic tx_steady = 1'b0;
	logic rx_steady = 1'b0;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;

	queue_machine_execute_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.reg_first     (reg_first),
		.reg_second    (reg_second),
		.immediate     (immediate),
		.jump_target   (jump_target),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.print_valid   (print_valid),
		.print_is_char (print_is_char),
		.print_value   (print_value),
		.branch_taken  (branch_taken),
		.branch_to     (branch_to),
		.halted        (halted),
		.error_code    (error_code)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// register read, out of range indexes read as zero
	function automatic logic [DATA_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
		if (idx < NUM_REGS)
			return vm_regs[idx];
		return '0;
	endfunction

	// executes one instruction on the predicted state and returns its result
	function automatic outcome_t execute_instr(input instr_t ins);
		outcome_t r;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] res;
		logic take;
		r = '0;
		take = 1'b0;
		if (vm_halted) begin
			r.halted = 1'b1;
			return r;
		end
		case (ins.mode)
			OP_PUSH, OP_PUSHREG: begin
				if (vm_queue.size() >= QUEUE_DEPTH)
					r.error_code = ERR_OVER;
				else begin
					res = (ins.mode == OP_PUSH) ? ins.immediate : reg_value(ins.reg_first);
					vm_queue = {vm_queue, res};
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				if (vm_queue.size() < 2) begin
					r.error_code = ERR_UNDER;
				end else begin
					// x is the older value, y the next
					x = vm_queue.pop_front();
					y = vm_queue.pop_front();
					case (ins.mode)
						OP_ADD: res = x + y;
						OP_SUB: res = x - y;
						OP_MUL: res = x * y;
						OP_DIV: res = (y == '0) ? '0 : x / y;
						default: res = (y == '0) ? '0 : x % y;
					endcase
					vm_queue = {vm_queue, res};
				end
			end
			OP_POPREG, OP_PRINTQ, OP_PRINTCQ: begin
				if (vm_queue.size() < 1) begin
					r.error_code = ERR_UNDER;
				end else begin
					x = vm_queue.pop_front();
					if (ins.mode == OP_POPREG) begin
						if (ins.reg_first < NUM_REGS)
							vm_regs[ins.reg_first] = x;
					end else begin
						r.print_valid = 1'b1;
						r.print_is_char = (ins.mode == OP_PRINTCQ);
						r.print_value = (ins.mode == OP_PRINTCQ) ? DATA_W'(x[CHAR_W-1:0]) : x;
					end
				end
			end
			OP_PRINTR: begin
				r.print_valid = 1'b1;
				r.print_value = reg_value(ins.reg_first);
			end
			OP_PRINTCR: begin
				x = reg_value(ins.reg_first);
				r.print_valid = 1'b1;
				r.print_is_char = 1'b1;
				r.print_value = DATA_W'(x[CHAR_W-1:0]);
			end
			OP_JMP: take = 1'b1;
			OP_JZ:  take = (reg_value(ins.reg_first) == '0);
			OP_JEQ: take = (reg_value(ins.reg_first) == reg_value(ins.reg_second));
			OP_JGT: take = (reg_value(ins.reg_first) > reg_value(ins.reg_second));
			OP_QUIT: vm_halted = 1'b1;
			default: ;
		endcase
		r.branch_taken = take;
		r.branch_to = take ? ins.jump_target : '0;
		r.halted = vm_halted;
		return r;
	endfunction

	// drives one instruction and waits for its beat to be taken
	task automatic issue_instr(input instr_t ins);
		outcome_t predicted;
		@(negedge clk);
		while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= ins.mode;
		reg_first   <= ins.reg_first;
		reg_second  <= ins.reg_second;
		immediate   <= ins.immediate;
		jump_target <= ins.jump_target;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = execute_instr(ins);
		expected_outcomes = {expected_outcomes, predicted};
	endtask

	// stops offering and waits for every outstanding result
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	function automatic instr_t make_instr(input logic [MODE_W-1:0] op,
			input logic [REG_IDX_W-1:0] ra, input logic [REG_IDX_W-1:0] rb,
			input logic [DATA_W-1:0] imm, input logic [TGT_W-1:0] tgt);
		instr_t ins;
		ins.mode = op;
		ins.reg_first = ra;
		ins.reg_second = rb;
		ins.immediate = imm;
		ins.jump_target = tgt;
		return ins;
	endfunction

	function automatic logic [REG_IDX_W-1:0] random_reg();
		if ($urandom_range(0, 9) == 0)
			return REG_IDX_W'($urandom_range(NUM_REGS, REG_MAX));
		return REG_IDX_W'($urandom_range(0, NUM_REGS - 1));
	endfunction

	// values biased towards zero, small numbers and the extremes
	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return DATA_MAX;
			2: return DATA_W'($urandom_range(1, 3));
			3: return {1'b1, {(DATA_W - 1){1'b0}}};
			default: return DATA_W'($urandom());
		endcase
	endfunction

	function automatic instr_t random_operands();
		instr_t ins;
		ins.mode = OP_NOP;
		ins.reg_first = random_reg();
		ins.reg_second = ($urandom_range(0, 5) == 0) ? ins.reg_first : random_reg();
		ins.immediate = random_value();
		ins.jump_target = TGT_W'($urandom_range(0, TGT_MAX));
		return ins;
	endfunction

	// mostly well-formed steps, steered by the queue fill, plus some noise
	function automatic instr_t next_program_step();
		instr_t ins;
		int depth;
		int push_w;
		int roll;
		ins = random_operands();
		depth = vm_queue.size();
		push_w = (depth < 4) ? 60 : (depth > 240) ? 10 : 35;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 8) begin
			ins.mode = MODE_W'($urandom_range(0, OP_UNUSED_LAST));
			if (ins.mode == OP_QUIT)
				ins.mode = OP_NOP;
		end else if (roll < push_w) begin
			ins.mode = ($urandom_range(0, 9) < 7) ? OP_PUSH : OP_PUSHREG;
		end else if (roll < push_w + 30) begin
			ins.mode = MODE_W'($urandom_range(OP_ADD, OP_MOD));
		end else if (roll < push_w + 50) begin
			case ($urandom_range(0, 4))
				0: ins.mode = OP_POPREG;
				1: ins.mode = OP_PRINTQ;
				2: ins.mode = OP_PRINTCQ;
				3: ins.mode = OP_PRINTR;
				default: ins.mode = OP_PRINTCR;
			endcase
		end else if ($urandom_range(0, 9) != 0) begin
			ins.mode = MODE_W'($urandom_range(OP_JMP, OP_JGT));
		end else begin
			ins.mode = ($urandom_range(0, 1) == 0) ? OP_NOP
				: MODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		end
		return ins;
	endfunction

	// empty queue and zero registers: underflows, jumps on zero, nops
	task automatic test_empty_queue();
		issue_instr(make_instr(OP_ADD, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_DIV, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_POPREG, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PRINTQ, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PRINTCQ, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_JZ, REG_A, REG_A, '0, TGT_MAX));
		issue_instr(make_instr(OP_JEQ, REG_MAX, REG_B, '0, '0));
		issue_instr(make_instr(OP_JGT, REG_A, REG_B, '0, TGT_MAX));
		issue_instr(make_instr(OP_NOP, REG_MAX, REG_MAX, DATA_MAX, TGT_MAX));
		issue_instr(make_instr(OP_UNUSED_LAST, REG_MAX, REG_MAX, DATA_MAX, TGT_MAX));
	endtask

	// wrap-around, zero divisors, register moves and prints
	task automatic test_arith_edges();
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, DATA_MAX, '0));
		issue_instr(make_instr(OP_SUB, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, DATA_MAX, '0));
		issue_instr(make_instr(OP_ADD, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_DIV, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_MOD, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, DATA_W'(1), '0));
		issue_instr(make_instr(OP_SUB, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_PUSH, REG_A, REG_A, DATA_W'(16'hABCD), '0));
		issue_instr(make_instr(OP_MUL, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_POPREG, REG_Y, REG_A, '0, '0));
		issue_instr(make_instr(OP_PRINTCR, REG_Y, REG_A, '0, '0));
		issue_instr(make_instr(OP_PRINTR, REG_Y, REG_A, '0, '0));
		issue_instr(make_instr(OP_JGT, REG_Y, REG_Z, '0, TGT_W'(512)));
		issue_instr(make_instr(OP_PUSHREG, REG_OOR, REG_A, '0, '0));
		issue_instr(make_instr(OP_POPREG, REG_MAX, REG_A, '0, '0));
	endtask

	// receiver held off while the queue is filled to overflow
	task automatic test_queue_full();
		instr_t ins;
		holds_asked++;
		while (vm_queue.size() < QUEUE_DEPTH) begin
			ins = random_operands();
			ins.mode = ($urandom_range(0, 3) == 0) ? OP_PUSHREG : OP_PUSH;
			issue_instr(ins);
		end
		for (int i = 0; i < OVERFLOW_TRIES; i++) begin
			ins = random_operands();
			ins.mode = (i % 2 == 0) ? OP_PUSH : OP_PUSHREG;
			issue_instr(ins);
		end
	endtask

	// random programs with a steady stretch and a full pause midway
	task automatic test_random_programs(input int count);
		for (int i = 0; i < count; i++) begin
			tx_steady = (i >= count / 4) && (i < count / 4 + STEADY_LEN);
			rx_steady = tx_steady;
			if (i == count / 2)
				wait_results_drained();
			issue_instr(next_program_step());
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// quit, then items that must have no effect
	task automatic test_quit_and_after();
		instr_t ins;
		ins = random_operands();
		ins.mode = OP_QUIT;
		issue_instr(ins);
		ins = random_operands();
		ins.mode = OP_PUSH;
		issue_instr(ins);
		issue_instr(make_instr(OP_PRINTR, REG_Y, REG_A, '0, '0));
		issue_instr(make_instr(OP_JMP, REG_A, REG_A, '0, TGT_MAX));
		issue_instr(make_instr(OP_ADD, REG_A, REG_A, '0, '0));
		issue_instr(make_instr(OP_QUIT, REG_A, REG_A, '0, '0));
	endtask

	// receiver: random ready, long hold-offs on request
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			hold_left = HOLD_CYCLES;
			holds_served++;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= rx_steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n && out_valid && out_ready) begin
			got.print_valid   = print_valid;
			got.print_is_char = print_is_char;
			got.print_value   = print_value;
			got.branch_taken  = branch_taken;
			got.branch_to     = branch_to;
			got.halted        = halted;
			got.error_code    = err_t'(error_code);
			if (expected_outcomes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result beat %0d with nothing outstanding", result_beats);
			end else begin
				want = expected_outcomes.pop_front();
				if (got.print_valid !== want.print_valid
						|| got.print_is_char !== want.print_is_char
						|| got.print_value !== want.print_value
						|| got.branch_taken !== want.branch_taken
						|| got.branch_to !== want.branch_to
						|| got.halted !== want.halted
						|| got.error_code !== want.error_code) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("beat %0d: expected pv=%b pc=%b val=%h bt=%b to=%0d halt=%b err=%0d",
							result_beats, want.print_valid, want.print_is_char,
							want.print_value, want.branch_taken, want.branch_to,
							want.halted, want.error_code);
						$display("beat %0d: got      pv=%b pc=%b val=%h bt=%b to=%0d halt=%b err=%0d",
							result_beats, got.print_valid, got.print_is_char,
							got.print_value, got.branch_taken, got.branch_to,
							got.halted, got.error_code);
					end
				end
			end
			result_beats++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** queue_machine_execute_top: FAILED **");
			$finish;
		end
	end

	initial begin
		foreach (vm_regs[i])
			vm_regs[i] = '0;
		vm_halted = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_queue();
		test_arith_edges();
		test_queue_full();
		test_random_programs(RANDOM_ITEMS);
		test_quit_and_after();

		wait_results_drained();
		repeat (END_WAIT) @(posedge clk);
		if (mismatch_count == 0 && expected_outcomes.size() == 0)
			$display("** queue_machine_execute_top: PASSED **");
		else
			$display("** queue_machine_execute_top: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
